/* src/lal_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lal_pkg
// Shared types, widths and register codes of the lateral acceleration
// limiter with first-order lowpass.
// ----------------------------------------------------------------------------
package lal_pkg;

  typedef logic signed [15:0] q7_8_t;
  typedef logic signed [31:0] q7_24_t;
  typedef logic        [15:0] u16_t;
  typedef logic        [1:0]  cfg_idx_t;

  localparam cfg_idx_t CFG_ACCEL_LIMIT  = 2'd0;
  localparam cfg_idx_t CFG_GAIN_LINEAR  = 2'd1;
  localparam cfg_idx_t CFG_GAIN_ANGULAR = 2'd2;

  localparam u16_t ACCEL_LIMIT_RST = 16'd1280;

  localparam int DIV_BITS  = 24;
  localparam int MUL_BITS  = 16;
  localparam int CNT_W     = 5;

endpackage

/* src/lal_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lal_in_if
// Command channel: linear speed and yaw rate, valid/ready.
// ----------------------------------------------------------------------------
interface lal_in_if;
  import lal_pkg::*;

  logic  valid;
  logic  ready;
  q7_8_t speed_in;
  q7_8_t yaw_rate_in;

  modport source (output valid, output speed_in, output yaw_rate_in, input ready);
  modport sink   (input valid, input speed_in, input yaw_rate_in, output ready);
endinterface

/* src/lal_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lal_out_if
// Result channel: filtered speed and yaw rate, valid/ready.
// ----------------------------------------------------------------------------
interface lal_out_if;
  import lal_pkg::*;

  logic  valid;
  logic  ready;
  q7_8_t speed_out;
  q7_8_t yaw_rate_out;

  modport source (output valid, output speed_out, output yaw_rate_out, input ready);
  modport sink   (input valid, input speed_out, input yaw_rate_out, output ready);
endinterface

/* src/lal_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lal_cfg_if
// Register write channel: index and data, valid/ready.
// ----------------------------------------------------------------------------
interface lal_cfg_if;
  import lal_pkg::*;

  logic     valid;
  logic     ready;
  cfg_idx_t index;
  u16_t     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/lateral_accel_limit_lowpass_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lateral_accel_limit_lowpass_core
// Limits the lateral acceleration of a velocity command, then lowpasses
// speed and yaw rate with separate first-order IIR filters.
//
// Channels: in_chan takes one command item (speed_in, yaw_rate_in, Q7.8);
// out_chan returns one item (speed_out, yaw_rate_out) per command, in order.
// cfg_chan writes accel_limit (0), gain_linear (1), gain_angular (2); other
// indexes are dropped. cfg_chan is always ready.
// Steps: for a command with nonzero yaw rate, a restoring divider (one
// quotient bit per cycle) gives accel_limit / |yaw|, one state picks the
// limited speed, one forms the filter differences, both filters run a
// bit-serial multiply by their gain, and one state writes back. A zero yaw
// rate goes straight to write-back: speed passes unfiltered, yaw rate out
// is 0 and the filter memories are kept. One command is in work at a time:
// a new command is taken only after the last one is written back;
// in_chan.ready is high while the block is idle, also while a finished item
// waits in the output register.
// Stall: a held result blocks only the final write-back of the next item.
// Reset: filter memories clear, registers go to accel_limit 5.0 and gains 0.
// ----------------------------------------------------------------------------
module lateral_accel_limit_lowpass_core (
  input  logic     clk,
  input  logic     rst_n,
  lal_cfg_if.sink  cfg_chan,
  lal_in_if.sink   in_chan,
  lal_out_if.source out_chan
);
  import lal_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_LIM  = 3'd2;
  localparam logic [2:0] ST_DIFF = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_BITS - 1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_BITS - 1);

  logic [2:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  u16_t                    limit_r, limit_nxt;
  u16_t                    gain_lin_r, gain_lin_nxt;
  u16_t                    gain_ang_r, gain_ang_nxt;
  q7_8_t                   speed_r, speed_nxt;
  q7_8_t                   yaw_r, yaw_nxt;
  u16_t                    absv_r, absv_nxt;
  u16_t                    absw_r, absw_nxt;
  logic                    zero_r, zero_nxt;
  logic [DIV_BITS-1:0]     num_r, num_nxt;
  u16_t                    rem_r, rem_nxt;
  q7_8_t                   x_lin_r, x_lin_nxt;
  logic signed [32:0]      d_lin_r, d_lin_nxt;
  logic signed [32:0]      d_ang_r, d_ang_nxt;
  logic signed [34:0]      acc_lin_r, acc_lin_nxt;
  logic signed [34:0]      acc_ang_r, acc_ang_nxt;
  u16_t                    g_lin_sh_r, g_lin_sh_nxt;
  u16_t                    g_ang_sh_r, g_ang_sh_nxt;
  q7_24_t                  mem_lin_r, mem_lin_nxt;
  q7_24_t                  mem_ang_r, mem_ang_nxt;
  logic                    out_valid_r, out_valid_nxt;
  q7_8_t                   out_speed_r, out_speed_nxt;
  q7_8_t                   out_yaw_r, out_yaw_nxt;

  logic                    in_fire;
  logic                    out_free;
  logic [16:0]             div_shift;
  logic [16:0]             div_diff;
  logic                    div_ge;
  logic                    over;
  q7_8_t                   sat_q;
  logic signed [34:0]      add_lin;
  logic signed [34:0]      add_ang;
  q7_24_t                  mem_lin_new;
  q7_24_t                  mem_ang_new;

  assign cfg_chan.ready     = 1'b1;
  assign in_chan.ready      = (state_r == ST_IDLE);
  assign in_fire            = in_chan.valid && in_chan.ready;
  assign out_free           = !out_valid_r || out_chan.ready;
  assign out_chan.valid     = out_valid_r;
  assign out_chan.speed_out = out_speed_r;
  assign out_chan.yaw_rate_out = out_yaw_r;

  assign div_shift = {rem_r, num_r[DIV_BITS-1]};
  assign div_diff  = div_shift - {1'b0, absw_r};
  assign div_ge    = (div_shift >= {1'b0, absw_r});

  assign over = ({{(DIV_BITS-16){1'b0}}, absv_r} > num_r);

  always_comb begin
    if (!yaw_r[15]) begin
      sat_q = (num_r > DIV_BITS'(32767)) ? 16'sh7FFF : q7_8_t'(num_r[15:0]);
    end else begin
      sat_q = (num_r > DIV_BITS'(32768)) ? 16'sh8000 : q7_8_t'(~num_r[15:0] + 16'd1);
    end
  end

  assign add_lin = acc_lin_r + (g_lin_sh_r[0] ? {{2{d_lin_r[32]}}, d_lin_r} : 35'sd0);
  assign add_ang = acc_ang_r + (g_ang_sh_r[0] ? {{2{d_ang_r[32]}}, d_ang_r} : 35'sd0);

  assign mem_lin_new = {x_lin_r, 16'd0} + acc_lin_r[31:0];
  assign mem_ang_new = {yaw_r, 16'd0} + acc_ang_r[31:0];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    limit_nxt     = limit_r;
    gain_lin_nxt  = gain_lin_r;
    gain_ang_nxt  = gain_ang_r;
    speed_nxt     = speed_r;
    yaw_nxt       = yaw_r;
    absv_nxt      = absv_r;
    absw_nxt      = absw_r;
    zero_nxt      = zero_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    x_lin_nxt     = x_lin_r;
    d_lin_nxt     = d_lin_r;
    d_ang_nxt     = d_ang_r;
    acc_lin_nxt   = acc_lin_r;
    acc_ang_nxt   = acc_ang_r;
    g_lin_sh_nxt  = g_lin_sh_r;
    g_ang_sh_nxt  = g_ang_sh_r;
    mem_lin_nxt   = mem_lin_r;
    mem_ang_nxt   = mem_ang_r;
    out_valid_nxt = out_valid_r;
    out_speed_nxt = out_speed_r;
    out_yaw_nxt   = out_yaw_r;

    if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_ACCEL_LIMIT:  limit_nxt    = cfg_chan.data;
        CFG_GAIN_LINEAR:  gain_lin_nxt = cfg_chan.data;
        CFG_GAIN_ANGULAR: gain_ang_nxt = cfg_chan.data;
        default: ;
      endcase
    end

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          speed_nxt = in_chan.speed_in;
          yaw_nxt   = in_chan.yaw_rate_in;
          absv_nxt  = in_chan.speed_in[15] ? (~in_chan.speed_in + 16'd1) : in_chan.speed_in;
          absw_nxt  = in_chan.yaw_rate_in[15] ? (~in_chan.yaw_rate_in + 16'd1)
                                              : in_chan.yaw_rate_in;
          zero_nxt  = (in_chan.yaw_rate_in == 16'sd0);
          num_nxt   = {limit_r, 8'd0};
          rem_nxt   = 16'd0;
          cnt_nxt   = '0;
          state_nxt = (in_chan.yaw_rate_in == 16'sd0) ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        num_nxt = {num_r[DIV_BITS-2:0], div_ge};
        rem_nxt = div_ge ? div_diff[15:0] : div_shift[15:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_LIM;
        end
      end
      ST_LIM: begin
        x_lin_nxt = over ? sat_q : speed_r;
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        d_lin_nxt    = {mem_lin_r[31], mem_lin_r} - {x_lin_r[15], x_lin_r, 16'd0};
        d_ang_nxt    = {mem_ang_r[31], mem_ang_r} - {yaw_r[15], yaw_r, 16'd0};
        acc_lin_nxt  = '0;
        acc_ang_nxt  = '0;
        g_lin_sh_nxt = gain_lin_r;
        g_ang_sh_nxt = gain_ang_r;
        cnt_nxt      = '0;
        state_nxt    = ST_MUL;
      end
      ST_MUL: begin
        acc_lin_nxt  = add_lin >>> 1;
        acc_ang_nxt  = add_ang >>> 1;
        g_lin_sh_nxt = {1'b0, g_lin_sh_r[15:1]};
        g_ang_sh_nxt = {1'b0, g_ang_sh_r[15:1]};
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == MUL_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (zero_r) begin
            out_speed_nxt = speed_r;
            out_yaw_nxt   = 16'sd0;
          end else begin
            out_speed_nxt = mem_lin_new[31:16];
            out_yaw_nxt   = mem_ang_new[31:16];
            mem_lin_nxt   = mem_lin_new;
            mem_ang_nxt   = mem_ang_new;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      limit_r     <= ACCEL_LIMIT_RST;
      gain_lin_r  <= '0;
      gain_ang_r  <= '0;
      mem_lin_r   <= '0;
      mem_ang_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      limit_r     <= limit_nxt;
      gain_lin_r  <= gain_lin_nxt;
      gain_ang_r  <= gain_ang_nxt;
      mem_lin_r   <= mem_lin_nxt;
      mem_ang_r   <= mem_ang_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    speed_r     <= speed_nxt;
    yaw_r       <= yaw_nxt;
    absv_r      <= absv_nxt;
    absw_r      <= absw_nxt;
    zero_r      <= zero_nxt;
    num_r       <= num_nxt;
    rem_r       <= rem_nxt;
    x_lin_r     <= x_lin_nxt;
    d_lin_r     <= d_lin_nxt;
    d_ang_r     <= d_ang_nxt;
    acc_lin_r   <= acc_lin_nxt;
    acc_ang_r   <= acc_ang_nxt;
    g_lin_sh_r  <= g_lin_sh_nxt;
    g_ang_sh_r  <= g_ang_sh_nxt;
    out_speed_r <= out_speed_nxt;
    out_yaw_r   <= out_yaw_nxt;
  end

endmodule

/* src/lal_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lal_checker
// Port-level checks of the core's handshakes and one-at-a-time operation.
// ----------------------------------------------------------------------------
module lal_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input lal_pkg::q7_8_t speed_out,
  input lal_pkg::q7_8_t yaw_rate_out
);
  import lal_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(speed_out) && $stable(yaw_rate_out))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in work");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without an item in work");

endmodule

bind lateral_accel_limit_lowpass_core lal_checker u_lal_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .speed_out    (out_chan.speed_out),
  .yaw_rate_out (out_chan.yaw_rate_out)
);
